### src/mavg_pkg.sv
package mavg_pkg;

  // Fixed field widths
  localparam int SAMPLE_W       = 16;
  localparam int WL_W           = 7;

  // Defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int WL_RESET       = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } mavg_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_write;
    logic in_take;
    logic rd_en;
    logic update;
    logic div_step;
    logic out_load;
  } mavg_cmd_t;

  // Width of the sum magnitude, which is also the number of divide steps
  function automatic int mag_width(input int max_window);
    return SAMPLE_W + $clog2(max_window);
  endfunction

endpackage

### src/mavg_ctrl.sv
module mavg_ctrl #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output mavg_pkg::mavg_cmd_t cmd
);
  import mavg_pkg::*;

  localparam int MAG_W  = mag_width(MAX_WINDOW);
  localparam int STEP_W = $clog2(MAG_W);

  mavg_state_t       state;
  mavg_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;
  logic              last_step;
  logic              out_free;

  assign last_step = (step == STEP_W'(MAG_W - 1));
  assign out_free  = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) state_next = ST_READ;
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIV;
      ST_DIV: begin
        if (last_step) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    step_next    = step;
    unique case (state)
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        in_stall      = cfg_valid;
        cmd.cfg_write = cfg_valid;
        cmd.in_take   = in_valid && !cfg_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        step_next  = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output request flag: set on load, drop when taken
  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      step      <= step_next;
    end
  end

endmodule

### src/mavg_dp.sv
module mavg_dp #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mavg_pkg::mavg_cmd_t                 cmd,
  input  logic [mavg_pkg::WL_W-1:0]           window_length,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] average,
  output logic                                window_full
);
  import mavg_pkg::*;

  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int MAG_W   = mag_width(MAX_WINDOW);
  localparam int SUM_W   = MAG_W + 1;
  localparam int CMP_W   = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam int WIN_RST = (WL_RESET > MAX_WINDOW) ? MAX_WINDOW : WL_RESET;

  // Sample history
  logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];

  logic [CNT_W-1:0]           win;
  logic [POS_W-1:0]           pos;
  logic [CNT_W-1:0]           count;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [SAMPLE_W-1:0] rd_data;

  logic                       neg;
  logic [MAG_W-1:0]           dvd;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           dvs;
  logic                       full_pend;

  logic [CMP_W-1:0]           wl_ext;
  logic [CNT_W-1:0]           win_wr;
  logic                       fill;
  logic signed [SAMPLE_W-1:0] old;
  logic signed [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           pos_inc;
  logic [POS_W-1:0]           pos_next;
  logic [SUM_W-1:0]           sum_abs;
  logic [CNT_W:0]             rem_sh;
  logic                       rem_ge;
  logic [CNT_W:0]             rem_sub;
  logic [SAMPLE_W-1:0]        quo;

  // Limit the written window length to 1..MAX_WINDOW
  assign wl_ext = CMP_W'(window_length);
  always_comb begin
    priority if (wl_ext == '0) begin
      win_wr = CNT_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      win_wr = CNT_W'(MAX_WINDOW);
    end else begin
      win_wr = CNT_W'(wl_ext);
    end
  end

  // Sum, count and position update; slots not yet filled read as zero
  assign fill       = (count < win);
  assign old        = fill ? '0 : rd_data;
  assign sum_next   = sum + SUM_W'(smp) - SUM_W'(old);
  assign count_next = fill ? count + CNT_W'(1) : count;
  assign pos_inc    = CNT_W'(pos) + CNT_W'(1);
  assign pos_next   = (pos_inc == win) ? '0 : pos_inc[POS_W-1:0];
  assign sum_abs    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

  // One restoring divide step
  assign rem_sh  = {rem, dvd[MAG_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign quo     = dvd[SAMPLE_W-1:0];

  // Control state: window, position, count and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= CNT_W'(WIN_RST);
      pos   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.cfg_write) begin
      win   <= win_wr;
      pos   <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.update) begin
      pos   <= pos_next;
      count <= count_next;
      sum   <= sum_next;
    end
  end

  // History memory: registered read, write on update
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= hist[pos];
    end
    if (cmd.update) begin
      hist[pos] <= smp;
    end
  end

  // Capture the request sample
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      smp <= sample;
    end
  end

  // Divider: load magnitude, then shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      neg       <= sum_next[SUM_W-1];
      dvd       <= sum_abs[MAG_W-1:0];
      rem       <= '0;
      dvs       <= count_next;
      full_pend <= (count_next == win);
    end else if (cmd.div_step) begin
      dvd <= {dvd[MAG_W-2:0], rem_ge};
      rem <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // Output register: restore the sign
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average     <= neg ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
      window_full <= full_pend;
    end
  end

endmodule

### src/moving_average_filter.sv
// Moving average filter over a ring of the last window_length samples.
// A taken sample passes through the READ, UPDATE, DIV (bit-serial divider)
// and DONE states before the result request is raised.
// One sample in flight: a new sample is taken only after its result is loaded.
// Reset (rst, synchronous): window 64 clamped to MAX_WINDOW, history empty,
// sum, count and position zero; a window_length write clears all but the window.
module moving_average_filter #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] average,
  output logic                                 window_full,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mavg_pkg::WL_W-1:0]            window_length
);
  import mavg_pkg::*;

  mavg_cmd_t cmd;

  mavg_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  mavg_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .window_length (window_length),
    .sample        (sample),
    .average       (average),
    .window_full   (window_full)
  );

  // A config write and a sample request never land together
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    !((in_valid && !in_stall) && (cfg_valid && cfg_ready)))
    else $error("config write taken with a sample");

  // One sample in flight: stall right after a request is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample taken while busy");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // A new result request only follows a load
  a_rise_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result request without load");

endmodule
